FILE: src/kpts_pkg.sv
// ----------------------------------------------------------------------------
// kpts_pkg
// Types and constants shared by the keyed port transfer sequencer, its
// port checker and its test bench.
// ----------------------------------------------------------------------------
package kpts_pkg;

	// Item commands
	typedef enum logic [1:0] {
		CMD_START_READ  = 2'd0,
		CMD_START_WRITE = 2'd1,
		CMD_LOAD_BYTE   = 2'd2,
		CMD_POLL_TICK   = 2'd3
	} command_t;

	// Result outcome codes
	typedef enum logic [1:0] {
		OUTCOME_NONE      = 2'd0,
		OUTCOME_COMPLETED = 2'd1,
		OUTCOME_TIMEOUT   = 2'd2,
		OUTCOME_REJECTED  = 2'd3
	} outcome_t;

	// Transfer phase
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_CMD  = 2'd1,
		PH_KEY  = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	// Configuration register indexes
	typedef logic [1:0] cfg_index_t;
	localparam cfg_index_t CFG_RETRY_LIMIT = 2'd0;
	localparam cfg_index_t CFG_READ_CODE   = 2'd1;
	localparam cfg_index_t CFG_WRITE_CODE  = 2'd2;

	// Configuration reset values
	localparam logic [7:0] RETRY_LIMIT_RESET = 8'd100;
	localparam logic [7:0] READ_CODE_RESET   = 8'h10;
	localparam logic [7:0] WRITE_CODE_RESET  = 8'h11;

	// Expected status low nibbles
	localparam logic [3:0] NIB_CMD_ACK     = 4'hC;
	localparam logic [3:0] NIB_WRITE_READY = 4'h4;
	localparam logic [3:0] NIB_READ_READY  = 4'h5;

	// Number of key bytes sent after the command byte
	localparam logic [5:0] KEY_BYTES = 6'd4;

	typedef struct packed {
		command_t    command;
		logic [31:0] key;
		logic [5:0]  length;
		logic [4:0]  payload_index;
		logic [7:0]  payload_byte;
		logic [7:0]  status_in;
		logic [7:0]  data_in;
	} item_t;

	typedef struct packed {
		logic        port_write_valid;
		logic        to_command_port;
		logic [7:0]  port_write_byte;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic [4:0]  read_position;
		outcome_t    outcome;
		logic        busy_res;
		logic [7:0]  last_status;
	} result_t;

endpackage

FILE: src/kpts_ram.sv
// ----------------------------------------------------------------------------
// kpts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kpts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; hold the last word when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/keyed_port_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// keyed_port_transfer_sequencer_core
// Host-side master for a keyed controller behind a command/status port and a
// data port. Runs key read and key write transfers, one poll tick at a time.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   (item_valid / item_stall / item): start read, start write,
//                  load payload byte or poll tick. Every item yields one word.
//   result channel (result_valid / result_stall / result): one word per item,
//                  in item order, telling what byte to drive, which read byte
//                  was captured and how the transfer ended.
//   cfg channel    (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//                  retry limit and the two command codes; always ready.
//   Pipeline: the result word passes through the payload RAM stage and
//   the output register before it is presented.
//   Throughput: one item per cycle while item_stall is low; transfer
//   control updates in the accept cycle and the payload RAM read is
//   pipelined behind it.
//   Reset clears the transfer to idle, loads the register reset values and
//   empties the pipeline; the payload RAM is not cleared.
//   While result_stall is high the output word holds, one more word waits in
//   the RAM stage, and item_stall rises once both are occupied.
// ----------------------------------------------------------------------------
module keyed_port_transfer_sequencer_core #(
	parameter int MAX_PAYLOAD = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                item_valid,
	output logic                item_stall,
	input  kpts_pkg::item_t     item,
	// result channel
	output logic                result_valid,
	input  logic                result_stall,
	output kpts_pkg::result_t   result,
	// configuration channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  kpts_pkg::cfg_index_t cfg_index,
	input  logic [7:0]          cfg_data
);

	import kpts_pkg::*;

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	// Configuration registers
	logic [7:0] retry_limit_q;
	logic [7:0] read_code_q;
	logic [7:0] write_code_q;

	// Transfer state
	phase_t      phase_q, phase_nx;
	logic [3:0]  expect_q, expect_nx;
	logic [7:0]  polls_q, polls_nx;
	logic [5:0]  pos_q, pos_nx;
	logic [31:0] key_q, key_nx;
	logic [5:0]  len_q, len_nx;
	logic        wr_q, wr_nx;

	// Stage 1 and output stage
	logic        valid_s1;
	result_t     res_s1;
	logic        use_ram_s1;
	logic        result_valid_q;
	result_t     result_q;

	logic        accept;
	logic        advance_out;
	logic        advance_s1;
	result_t     res_nx;
	logic        use_ram_nx;
	result_t     res_merged;

	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Handshakes
	assign advance_out  = !result_valid_q || !result_stall;
	assign advance_s1   = valid_s1 && advance_out;
	assign item_stall   = valid_s1 && !advance_out;
	assign accept       = item_valid && !item_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RESET;
			read_code_q   <= READ_CODE_RESET;
			write_code_q  <= WRITE_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RETRY_LIMIT: retry_limit_q <= cfg_data;
				CFG_READ_CODE:   read_code_q   <= cfg_data;
				CFG_WRITE_CODE:  write_code_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload store: loads write, poll ticks read the current position
	assign ram_we    = accept && (item.command == CMD_LOAD_BYTE)
		&& ({3'b000, item.payload_index} < MAX_LEN);
	assign ram_waddr = AW'(item.payload_index);
	assign ram_re    = accept && (item.command == CMD_POLL_TICK);
	assign ram_raddr = AW'(pos_q);

	kpts_ram #(
		.WIDTH(8),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.payload_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Transfer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			expect_q <= '0;
			polls_q  <= '0;
			pos_q    <= '0;
			key_q    <= '0;
			len_q    <= '0;
			wr_q     <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_nx;
			expect_q <= expect_nx;
			polls_q  <= polls_nx;
			pos_q    <= pos_nx;
			key_q    <= key_nx;
			len_q    <= len_nx;
			wr_q     <= wr_nx;
		end
	end

	// Next transfer state and result word for the offered item
	always_comb begin
		logic [5:0] pos_inc;
		logic [3:0] data_nib;
		phase_nx   = phase_q;
		expect_nx  = expect_q;
		polls_nx   = polls_q;
		pos_nx     = pos_q;
		key_nx     = key_q;
		len_nx     = len_q;
		wr_nx      = wr_q;
		res_nx     = '0;
		use_ram_nx = 1'b0;
		pos_inc    = pos_q + 6'd1;
		data_nib   = wr_q ? NIB_WRITE_READY : NIB_READ_READY;

		unique case (item.command)
			CMD_START_READ, CMD_START_WRITE: begin
				if (phase_q != PH_IDLE || {2'b00, item.length} > MAX_LEN) begin
					res_nx.outcome = OUTCOME_REJECTED;
				end else begin
					wr_nx  = (item.command == CMD_START_WRITE);
					key_nx = item.key;
					len_nx = item.length;
					pos_nx = '0;
					res_nx.port_write_valid = 1'b1;
					res_nx.to_command_port  = 1'b1;
					res_nx.port_write_byte  = (item.command == CMD_START_WRITE)
						? write_code_q : read_code_q;
					phase_nx  = PH_CMD;
					expect_nx = NIB_CMD_ACK;
					polls_nx  = retry_limit_q;
				end
			end
			CMD_LOAD_BYTE: ;
			CMD_POLL_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (item.status_in[3:0] == expect_q) begin
						unique case (phase_q)
							PH_CMD: begin
								res_nx.port_write_valid = 1'b1;
								res_nx.port_write_byte  = key_q[31:24];
								pos_nx    = 6'd1;
								phase_nx  = PH_KEY;
								expect_nx = NIB_WRITE_READY;
								polls_nx  = retry_limit_q;
							end
							PH_KEY: begin
								res_nx.port_write_valid = 1'b1;
								if (pos_q < KEY_BYTES) begin
									case (pos_q[1:0])
										2'd1:    res_nx.port_write_byte = key_q[23:16];
										2'd2:    res_nx.port_write_byte = key_q[15:8];
										2'd3:    res_nx.port_write_byte = key_q[7:0];
										default: res_nx.port_write_byte = key_q[31:24];
									endcase
									pos_nx    = pos_inc;
									expect_nx = NIB_WRITE_READY;
									polls_nx  = retry_limit_q;
								end else begin
									res_nx.port_write_byte = {2'b00, len_q};
									pos_nx = '0;
									if (len_q == '0) begin
										phase_nx       = PH_IDLE;
										res_nx.outcome = OUTCOME_COMPLETED;
									end else begin
										phase_nx  = PH_DATA;
										expect_nx = data_nib;
										polls_nx  = retry_limit_q;
									end
								end
							end
							PH_DATA: begin
								if (wr_q) begin
									// byte comes from the RAM read issued now
									res_nx.port_write_valid = 1'b1;
									use_ram_nx = 1'b1;
								end else begin
									res_nx.read_valid    = 1'b1;
									res_nx.read_byte     = item.data_in;
									res_nx.read_position = pos_q[4:0];
								end
								pos_nx = pos_inc;
								if (pos_inc >= len_q) begin
									phase_nx       = PH_IDLE;
									res_nx.outcome = OUTCOME_COMPLETED;
								end else begin
									expect_nx = data_nib;
									polls_nx  = retry_limit_q;
								end
							end
							default: ;
						endcase
					end else if (polls_q == '0) begin
						phase_nx           = PH_IDLE;
						res_nx.outcome     = OUTCOME_TIMEOUT;
						res_nx.last_status = item.status_in;
					end else begin
						polls_nx = polls_q - 8'd1;
					end
				end
			end
			default: ;
		endcase

		res_nx.busy_res = (phase_nx != PH_IDLE);
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload; hold while stalled
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_nx;
			use_ram_s1 <= use_ram_nx;
		end
	end

	// Merge the RAM read byte into the word
	always_comb begin
		res_merged = res_s1;
		if (use_ram_s1) begin
			res_merged.port_write_byte = ram_rdata;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance_out) begin
			result_valid_q <= valid_s1;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_q <= res_merged;
		end
	end

endmodule

FILE: src/kpts_checker.sv
// ----------------------------------------------------------------------------
// kpts_checker
// Port-level checks of the keyed port transfer sequencer, bound to the top.
// ----------------------------------------------------------------------------
module kpts_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_stall,
	input logic                 result_valid,
	input logic                 result_stall,
	input kpts_pkg::result_t    result
);

	import kpts_pkg::*;

	// A stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Backpressure on items only while the result side is stalled
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("item stall without a stalled result");

	// A word never both drives a port byte and delivers a read byte
	a_drive_or_read: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_valid |-> !result.port_write_valid)
		else $error("read byte delivered together with a port write");

	// Status is reported only with a timeout, which ends the transfer
	a_timeout_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.last_status != 8'd0 || result.outcome == OUTCOME_TIMEOUT)
		|-> result.outcome == OUTCOME_TIMEOUT && !result.busy_res)
		else $error("status reported outside a timeout");

endmodule

bind keyed_port_transfer_sequencer_core kpts_checker u_kpts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

FILE: dv/keyed_port_transfer_sequencer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyed_port_transfer_sequencer_core_test
// Self-checking bench for the keyed port transfer sequencer. A generator
// builds key read and key write transfers with random keys, lengths, status
// misses, timeouts and busy-time noise. A driver feeds them one word at a
// time. A monitor compares each result word with an in-bench prediction of
// the transfer state machine. Each phase runs under its own register setting
// and its own pattern of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module keyed_port_transfer_sequencer_core_test;
	import kpts_pkg::*;

	localparam int MAX_PAYLOAD  = 32;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 800000;
	localparam int PHASE_ITEMS  = 165;

	typedef struct {
		item_t word;
		bit    drain_first;
	} pending_item_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	item_t      item;
	logic       result_valid;
	logic       result_stall;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	logic [7:0] cfg_data;

	// stimulus and expected words
	pending_item_t stimulus_q[$];
	pending_item_t next_pending;
	result_t       expected_words[$];

	// predicted transfer state
	phase_t      xfer_phase;
	logic [3:0]  want_nibble;
	logic [7:0]  polls_left;
	logic [5:0]  xfer_pos;
	logic [31:0] xfer_key;
	logic [5:0]  xfer_len;
	logic        xfer_write;
	logic [7:0]  payload_slots [0:MAX_PAYLOAD-1];

	// register shadows
	logic [7:0] retry_limit_q;
	logic [7:0] read_code_q;
	logic [7:0] write_code_q;

	// generator bookkeeping
	bit [MAX_PAYLOAD-1:0] gen_loaded;
	bit                   gen_busy;
	bit                   drain_next;
	int                   queued_items;

	int sender_idle_pct;
	int receiver_stall_pct;
	int mismatch_count;
	int words_checked;
	int cycle_count = 0;

	keyed_port_transfer_sequencer_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		$display("[%0t] word %0d: %s got 0x%0h want 0x%0h", $time, words_checked,
			what, got, want);
	endtask

	// advance the predicted transfer by one accepted word
	task automatic predict_word(input item_t it);
		result_t r;
		int sh;
		r = '0;
		case (it.command)
			CMD_START_READ, CMD_START_WRITE: begin
				if (xfer_phase != PH_IDLE || it.length > MAX_PAYLOAD) begin
					r.outcome = OUTCOME_REJECTED;
				end else begin
					xfer_write = (it.command == CMD_START_WRITE);
					xfer_key = it.key;
					xfer_len = it.length;
					xfer_pos = '0;
					r.port_write_valid = 1'b1;
					r.to_command_port = 1'b1;
					r.port_write_byte = xfer_write ? write_code_q : read_code_q;
					xfer_phase = PH_CMD;
					want_nibble = NIB_CMD_ACK;
					polls_left = retry_limit_q;
				end
			end
			CMD_LOAD_BYTE: begin
				if (it.payload_index < MAX_PAYLOAD)
					payload_slots[it.payload_index] = it.payload_byte;
			end
			default: begin
				if (xfer_phase == PH_IDLE) begin
					// idle poll: nothing happens
				end else if (it.status_in[3:0] == want_nibble) begin
					case (xfer_phase)
						PH_CMD: begin
							r.port_write_valid = 1'b1;
							r.port_write_byte = xfer_key[31:24];
							xfer_pos = 6'd1;
							xfer_phase = PH_KEY;
							want_nibble = NIB_WRITE_READY;
							polls_left = retry_limit_q;
						end
						PH_KEY: begin
							r.port_write_valid = 1'b1;
							if (xfer_pos < KEY_BYTES) begin
								sh = 8 * (3 - int'(xfer_pos));
								r.port_write_byte = 8'(xfer_key >> sh);
								xfer_pos++;
								want_nibble = NIB_WRITE_READY;
								polls_left = retry_limit_q;
							end else begin
								r.port_write_byte = {2'b00, xfer_len};
								xfer_pos = '0;
								if (xfer_len == 0) begin
									xfer_phase = PH_IDLE;
									r.outcome = OUTCOME_COMPLETED;
								end else begin
									xfer_phase = PH_DATA;
									want_nibble = xfer_write ? NIB_WRITE_READY : NIB_READ_READY;
									polls_left = retry_limit_q;
								end
							end
						end
						default: begin
							if (xfer_write) begin
								r.port_write_valid = 1'b1;
								r.port_write_byte = payload_slots[xfer_pos[4:0]];
							end else begin
								r.read_valid = 1'b1;
								r.read_byte = it.data_in;
								r.read_position = xfer_pos[4:0];
							end
							xfer_pos++;
							if (xfer_pos >= xfer_len) begin
								xfer_phase = PH_IDLE;
								r.outcome = OUTCOME_COMPLETED;
							end else begin
								want_nibble = xfer_write ? NIB_WRITE_READY : NIB_READ_READY;
								polls_left = retry_limit_q;
							end
						end
					endcase
				end else if (polls_left == 0) begin
					xfer_phase = PH_IDLE;
					r.outcome = OUTCOME_TIMEOUT;
					r.last_status = it.status_in;
				end else begin
					polls_left--;
				end
			end
		endcase
		r.busy_res = (xfer_phase != PH_IDLE);
		expected_words.push_back(r);
	endtask

	// compare a delivered word with the oldest prediction
	task automatic check_word(input result_t got);
		result_t want;
		if (expected_words.size() == 0) begin
			flag_mismatch("word with nothing pending", 64'(got), '0);
		end else begin
			want = expected_words.pop_front();
			if (got.port_write_valid !== want.port_write_valid)
				flag_mismatch("port_write_valid", 64'(got.port_write_valid),
					64'(want.port_write_valid));
			if (got.to_command_port !== want.to_command_port)
				flag_mismatch("to_command_port", 64'(got.to_command_port),
					64'(want.to_command_port));
			if (got.port_write_byte !== want.port_write_byte)
				flag_mismatch("port_write_byte", 64'(got.port_write_byte),
					64'(want.port_write_byte));
			if (got.read_valid !== want.read_valid)
				flag_mismatch("read_valid", 64'(got.read_valid), 64'(want.read_valid));
			if (got.read_byte !== want.read_byte)
				flag_mismatch("read_byte", 64'(got.read_byte), 64'(want.read_byte));
			if (got.read_position !== want.read_position)
				flag_mismatch("read_position", 64'(got.read_position),
					64'(want.read_position));
			if (got.outcome !== want.outcome)
				flag_mismatch("outcome", 64'(got.outcome), 64'(want.outcome));
			if (got.busy_res !== want.busy_res)
				flag_mismatch("busy_res", 64'(got.busy_res), 64'(want.busy_res));
			if (got.last_status !== want.last_status)
				flag_mismatch("last_status", 64'(got.last_status), 64'(want.last_status));
		end
		words_checked++;
	endtask

	// item driver: hold a stalled word, otherwise present the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				predict_word(item);
			if (!item_valid || !item_stall) begin
				if (stimulus_q.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
						!(stimulus_q[0].drain_first && expected_words.size() != 0)) begin
					next_pending = stimulus_q.pop_front();
					item <= next_pending.word;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_word(result);
			result_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	function automatic item_t random_word();
		item_t w;
		w.command = command_t'(2'($urandom_range(3)));
		w.key = $urandom;
		w.length = 6'($urandom);
		w.payload_index = 5'($urandom);
		w.payload_byte = 8'($urandom);
		w.status_in = 8'($urandom);
		w.data_in = 8'($urandom);
		return w;
	endfunction

	task automatic add_item(input item_t w);
		stimulus_q.push_back('{word: w, drain_first: drain_next || ($urandom_range(99) < 2)});
		drain_next = 1'b0;
		if (w.command != CMD_POLL_TICK || gen_busy)
			queued_items++;
	endtask

	task automatic add_load(input logic [4:0] slot, input logic [7:0] value);
		item_t w;
		w = random_word();
		w.command = CMD_LOAD_BYTE;
		w.payload_index = slot;
		w.payload_byte = value;
		gen_loaded[slot] = 1'b1;
		add_item(w);
	endtask

	task automatic add_poll(input logic [3:0] nib);
		item_t w;
		w = random_word();
		w.command = CMD_POLL_TICK;
		w.status_in[3:0] = nib;
		add_item(w);
	endtask

	// load or start issued while a transfer runs
	task automatic add_busy_noise();
		item_t w;
		if ($urandom_range(1)) begin
			add_load(5'($urandom), 8'($urandom));
		end else begin
			w = random_word();
			w.command = $urandom_range(1) ? CMD_START_WRITE : CMD_START_READ;
			add_item(w);
		end
	endtask

	// one status wait: some misses, then a match unless it is to time out
	task automatic run_wait(input logic [3:0] want, input bit kill, input bit calm,
			input int noise_pct);
		int misses;
		int roll;
		int k;
		logic [3:0] nib;
		if (kill) begin
			misses = retry_limit_q + 1;
		end else if (calm) begin
			misses = 0;
		end else begin
			roll = $urandom_range(99);
			if (roll < 55)
				misses = 0;
			else if (roll < 90)
				misses = $urandom_range(retry_limit_q < 3 ? retry_limit_q : 3);
			else if (retry_limit_q <= 40)
				misses = retry_limit_q;
			else
				misses = $urandom_range(retry_limit_q);
		end
		for (k = 0; k < misses; k++) begin
			if ($urandom_range(99) < noise_pct)
				add_busy_noise();
			do nib = 4'($urandom); while (nib == want);
			add_poll(nib);
		end
		if (!kill) begin
			if ($urandom_range(99) < noise_pct)
				add_busy_noise();
			add_poll(want);
		end
	endtask

	// full transfer: start, command ack, four key waits, then the data waits
	task automatic run_transfer(input bit wr, input logic [5:0] len, input logic [31:0] key,
			input bit calm, input int noise_pct);
		item_t w;
		int s;
		int n_waits;
		int kill_at;
		logic [3:0] want;
		// never send a slot that was not loaded
		if (wr)
			for (s = 0; s < len; s++)
				if (!gen_loaded[s] || $urandom_range(9) == 0)
					add_load(5'(s), 8'($urandom));
		w = random_word();
		w.command = wr ? CMD_START_WRITE : CMD_START_READ;
		w.key = key;
		w.length = len;
		add_item(w);
		gen_busy = 1'b1;
		n_waits = 5 + len;
		kill_at = -1;
		if (!calm && $urandom_range(99) < (retry_limit_q <= 20 ? 10 : 3))
			kill_at = $urandom_range(n_waits - 1);
		for (s = 0; s < n_waits; s++) begin
			if (s == 0)
				want = NIB_CMD_ACK;
			else if (s <= 4 || wr)
				want = NIB_WRITE_READY;
			else
				want = NIB_READ_READY;
			run_wait(want, s == kill_at, calm, noise_pct);
			if (s == kill_at)
				break;
		end
		gen_busy = 1'b0;
	endtask

	// wait until no word is in flight, then let the pipeline empty
	task automatic settle();
		do @(posedge clk);
		while (stimulus_q.size() != 0 || item_valid || expected_words.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input cfg_index_t idx, input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_RETRY_LIMIT: retry_limit_q = value;
			CFG_READ_CODE:   read_code_q = value;
			CFG_WRITE_CODE:  write_code_q = value;
			default: ;
		endcase
	endtask

	// one register setting with one idling pattern and random traffic
	task automatic run_phase(input logic [7:0] retry, input logic [7:0] rcode,
			input logic [7:0] wcode, input int idle_pct, input int stall_pct);
		item_t w;
		int roll;
		int len_roll;
		logic [5:0] len;
		settle();
		write_register(CFG_RETRY_LIMIT, retry);
		write_register(CFG_READ_CODE, rcode);
		write_register(CFG_WRITE_CODE, wcode);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		queued_items = 0;
		while (queued_items < PHASE_ITEMS) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				// mostly short transfers, now and then a long or full one
				len_roll = $urandom_range(99);
				if (len_roll < 60)
					len = 6'($urandom_range(4));
				else if (len_roll < 90)
					len = 6'($urandom_range(16, 5));
				else if (len_roll < 95)
					len = 6'($urandom_range(31, 17));
				else
					len = 6'(MAX_PAYLOAD);
				run_transfer(1'($urandom_range(1)), len, $urandom, 1'b0, 10);
			end else if (roll < 80) begin
				add_load(5'($urandom), 8'($urandom));
			end else if (roll < 88) begin
				add_poll(4'($urandom));
			end else begin
				// oversized start while idle
				w = random_word();
				w.command = $urandom_range(1) ? CMD_START_WRITE : CMD_START_READ;
				w.length = 6'($urandom_range(63, MAX_PAYLOAD + 1));
				add_item(w);
			end
		end
	endtask

	initial begin
		item_t w;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_RETRY_LIMIT;
		cfg_data = '0;
		retry_limit_q = RETRY_LIMIT_RESET;
		read_code_q = READ_CODE_RESET;
		write_code_q = WRITE_CODE_RESET;
		xfer_phase = PH_IDLE;
		want_nibble = '0;
		polls_left = '0;
		xfer_pos = '0;
		xfer_key = '0;
		xfer_len = '0;
		xfer_write = 1'b0;
		gen_loaded = '0;
		gen_busy = 1'b0;
		drain_next = 1'b0;
		queued_items = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		mismatch_count = 0;
		words_checked = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: idle poll, oversized starts, zero-length read with busy noise,
		// one-byte write after a drain pause, short read
		add_poll(4'($urandom));
		w = random_word();
		w.command = CMD_START_READ;
		w.length = 6'd63;
		add_item(w);
		w.command = CMD_START_WRITE;
		w.length = 6'(MAX_PAYLOAD + 1);
		add_item(w);
		run_transfer(1'b0, 6'd0, 32'hFFFF_FFFF, 1'b1, 30);
		add_load(5'd31, 8'h00);
		drain_next = 1'b1;
		add_load(5'd0, 8'hFF);
		run_transfer(1'b1, 6'd1, 32'h0000_0000, 1'b1, 30);
		run_transfer(1'b0, 6'd2, $urandom, 1'b1, 0);

		// random phases across register extremes and idling patterns
		run_phase(8'd3, 8'h00, 8'hFF, 0, 0);
		run_phase(8'd1, 8'hA5, 8'h5A, 80, 0);
		run_phase(8'd255, 8'hFF, 8'h00, 0, 80);
		run_phase(8'd0, 8'($urandom), 8'($urandom), 8, 8);
		run_phase(8'($urandom_range(8, 1)), 8'($urandom), 8'($urandom), 8, 8);
		run_phase(8'd2, READ_CODE_RESET, WRITE_CODE_RESET, 0, 0);
		run_phase(8'd10, 8'($urandom), 8'($urandom), 80, 0);
		run_phase(8'd5, 8'($urandom), 8'($urandom), 0, 80);

		settle();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
src/kpts_pkg.sv
src/kpts_ram.sv
src/keyed_port_transfer_sequencer_core.sv
src/kpts_checker.sv
dv/keyed_port_transfer_sequencer_core_test.sv
